FILE: hw/rtl/projectile_drag_integrator_macros.svh
// Assertion helpers shared by the RTL that checks its own behavior.
`ifndef PROJECTILE_DRAG_INTEGRATOR_MACROS_SVH
`define PROJECTILE_DRAG_INTEGRATOR_MACROS_SVH

// Same-cycle implication, checked on every rising clock edge out of reset.
`define PDI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset.
`define PDI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: hw/rtl/pdi_pkg.sv
`default_nettype none

package pdi_pkg;

  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_LAUNCH = 3'd1,
    OP_RESET  = 3'd2,
    OP_PAUSE  = 3'd3,
    OP_STEP   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    REG_WIND_X   = 3'd0,
    REG_WIND_Y   = 3'd1,
    REG_TARGET_X = 3'd2,
    REG_TARGET_Y = 3'd3,
    REG_RADIUS   = 3'd4,
    REG_DRAG     = 3'd5,
    REG_GRAVITY  = 3'd6,
    REG_DT       = 3'd7
  } cfg_reg_e;

  localparam logic signed [31:0] START_Y      = 32'sd98304;
  localparam logic [31:0]        DRAG_MIN     = 32'd66;
  localparam logic signed [24:0] DEG90        = 25'sd5898240;
  localparam logic signed [24:0] DEG180       = 25'sd11796480;
  localparam logic [31:0]        DEG_TO_RAD   = 32'd74961321;
  localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;

  localparam logic signed [31:0] RST_WIND_X   = 32'sd0;
  localparam logic signed [31:0] RST_WIND_Y   = 32'sd0;
  localparam logic signed [31:0] RST_TARGET_X = 32'sd1966080;
  localparam logic signed [31:0] RST_TARGET_Y = 32'sd98304;
  localparam logic [30:0]        RST_RADIUS   = 31'd32768;
  localparam logic [31:0]        RST_DRAG     = 32'd1518600;
  localparam logic [30:0]        RST_GRAVITY  = 31'd642690;
  localparam logic [31:0]        RST_DT       = 32'd17179869;

  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0:  r = 30'd843314857;
      5'd1:  r = 30'd497837829;
      5'd2:  r = 30'd263043837;
      5'd3:  r = 30'd133525159;
      5'd4:  r = 30'd67021687;
      5'd5:  r = 30'd33543516;
      5'd6:  r = 30'd16775851;
      5'd7:  r = 30'd8388437;
      5'd8:  r = 30'd4194283;
      5'd9:  r = 30'd2097149;
      5'd10: r = 30'd1048576;
      5'd11: r = 30'd524288;
      5'd12: r = 30'd262144;
      5'd13: r = 30'd131072;
      5'd14: r = 30'd65536;
      5'd15: r = 30'd32768;
      5'd16: r = 30'd16384;
      5'd17: r = 30'd8192;
      5'd18: r = 30'd4096;
      5'd19: r = 30'd2048;
      5'd20: r = 30'd1024;
      5'd21: r = 30'd512;
      5'd22: r = 30'd256;
      5'd23: r = 30'd128;
      5'd24: r = 30'd64;
      5'd25: r = 30'd32;
      5'd26: r = 30'd16;
      5'd27: r = 30'd8;
      5'd28: r = 30'd4;
      5'd29: r = 30'd2;
      default: r = 30'd0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    return v[31] ? 32'(-v) : 32'(v);
  endfunction

  function automatic logic [33:0] mag34(input logic signed [33:0] v);
    return v[33] ? 34'(-v) : 34'(v);
  endfunction

  function automatic logic signed [49:0] ext50(input logic signed [31:0] v);
    return {{18{v[31]}}, v};
  endfunction

  function automatic logic signed [49:0] smag(input logic neg, input logic [47:0] m);
    logic signed [49:0] p;
    p = $signed({2'b00, m});
    return neg ? -p : p;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [49:0] v);
    logic signed [31:0] r;
    if (v > 50'sd2147483647) begin
      r = 32'sh7fffffff;
    end else if (v < -50'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pdi_if.sv
`default_nettype none

interface pdi_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         op;
  logic [23:0]        launch_speed;
  logic signed [23:0] launch_angle;
  logic               pause_value;

  modport source(output valid, op, launch_speed, launch_angle, pause_value, input ready);
  modport sink(input valid, op, launch_speed, launch_angle, pause_value, output ready);
endinterface

interface pdi_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic [31:0]        elapsed;
  logic               in_flight;
  logic               target_hit;
  logic               last;

  modport source(output valid, pos_x, pos_y, vel_x, vel_y, elapsed, in_flight, target_hit,
                 last, input ready);
  modport sink(input valid, pos_x, pos_y, vel_x, vel_y, elapsed, in_flight, target_hit,
               last, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/pdi_sqrt.sv
`default_nettype none

module pdi_sqrt import pdi_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] radicand_i,
  output logic        done_o,
  output logic [31:0] root_o
);

  localparam logic [4:0] LAST_STEP = 5'd31;

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [63:0] rad_q;
  logic [33:0] rem_q;
  logic [31:0] root_q;

  logic [35:0] rem_sh;
  logic [35:0] trial;
  logic        ge;
  logic [33:0] rem_d;
  logic [31:0] root_d;

  always_comb begin
    rem_sh = {rem_q, rad_q[63:62]};
    trial  = {2'b00, root_q, 2'b01};
    ge     = (rem_sh >= trial);
    rem_d  = ge ? 34'(rem_sh - trial) : rem_sh[33:0];
    root_d = {root_q[30:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 5'd1;
      if (cnt_q == LAST_STEP) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rad_q  <= radicand_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (busy_q) begin
      rad_q  <= {rad_q[61:0], 2'b00};
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

endmodule

`default_nettype wire

FILE: hw/rtl/projectile_drag_integrator.sv
// Launch beat: ANG, CINIT, one CORDIC iteration per cycle, then VX, VY, VYW and back to idle.
// Tick beat: up to SUBSTEPS result beats; each uses the 32-step square root and up to 12
// passes through the shared 32x32 multiplier and waits in S_OUT while the output stalls.
// Other ops act on acceptance. One beat is in work at a time; input is not ready meanwhile.
// Reset is asynchronous and active low and returns registers and body state to defaults.
`default_nettype none
`include "projectile_drag_integrator_macros.svh"

module projectile_drag_integrator import pdi_pkg::*; #(
  parameter int unsigned SUBSTEPS          = 4,
  parameter int unsigned CORDIC_ITERATIONS = 24
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i,
  pdi_in_if.sink      in_i,
  pdi_out_if.source   res_o
);

  localparam int SW = (SUBSTEPS > 1) ? $clog2(SUBSTEPS) : 1;
  localparam int IW = $clog2(CORDIC_ITERATIONS);

  typedef enum logic [25:0] {
    S_IDLE  = 26'h0000001,
    S_ANG   = 26'h0000002,
    S_CINIT = 26'h0000004,
    S_CORD  = 26'h0000008,
    S_VX    = 26'h0000010,
    S_VY    = 26'h0000020,
    S_VYW   = 26'h0000040,
    S_REL   = 26'h0000080,
    S_SQX   = 26'h0000100,
    S_SQY   = 26'h0000200,
    S_SQS   = 26'h0000400,
    S_SQW   = 26'h0000800,
    S_K     = 26'h0001000,
    S_DX    = 26'h0002000,
    S_DY    = 26'h0004000,
    S_DYW   = 26'h0008000,
    S_AX    = 26'h0010000,
    S_AY    = 26'h0020000,
    S_PX    = 26'h0040000,
    S_PY    = 26'h0080000,
    S_PYW   = 26'h0100000,
    S_CHK   = 26'h0200000,
    S_EY    = 26'h0400000,
    S_R2    = 26'h0800000,
    S_HIT   = 26'h1000000,
    S_OUT   = 26'h2000000
  } state_e;

  state_e state_q;

  logic signed [31:0] wx_q, wy_q, tx_q, ty_q;
  logic [30:0]        tr_q, gr_q;
  logic [31:0]        df_q, dt_q;

  logic signed [31:0] px_q, py_q, vx_q, vy_q;
  logic [31:0]        el_q;
  logic               flying_q, hit_q, paused_q, step_q;

  logic [23:0]        spd_q;
  logic signed [24:0] ang_q;
  logic               flip_q;
  logic signed [33:0] x_q, y_q, z_q;
  logic [IW-1:0]      it_q;
  logic [SW-1:0]      cnt_q;

  logic signed [31:0] rx_q, ry_q;
  logic signed [49:0] dx_q, dy_q;
  logic [31:0]        k_q;
  logic [63:0]        acc_q;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod_q;

  logic        sq_start;
  logic        sq_done;
  logic [31:0] sq_root;

  logic               ov_q;
  logic signed [31:0] opx_q, opy_q, ovx_q, ovy_q;
  logic [31:0]        oel_q;
  logic               ofly_q, ohit_q, olast_q;

  logic               in_fire;
  logic signed [24:0] ang_ext, ang_red;
  logic               ang_flip;
  logic               tick_runs;
  logic signed [33:0] xs, ys, x_n, y_n, z_n, atan_s;
  logic               cord_last;
  logic signed [31:0] ax, ay;
  logic signed [32:0] ex, ey;
  logic [32:0]        ex_m, ey_m;
  logic               far;
  logic [32:0]        el_sum;
  logic               last_sub;
  logic               out_load;
  logic               sub_last;

  pdi_sqrt u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (sq_start),
    .radicand_i (acc_q + prod_q),
    .done_o     (sq_done),
    .root_o     (sq_root)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_fire    = in_i.valid && in_i.ready;
  assign tick_runs  = flying_q && (!paused_q || step_q);
  assign sq_start   = (state_q == S_SQS);
  assign last_sub   = (cnt_q == SW'(SUBSTEPS - 1));
  assign sub_last   = last_sub || !flying_q;
  assign out_load   = (state_q == S_OUT) && (!ov_q || res_o.ready);

  always_comb begin
    ang_ext  = {in_i.launch_angle[23], in_i.launch_angle};
    ang_red  = ang_ext;
    ang_flip = 1'b0;
    if (ang_ext > DEG90) begin
      ang_red  = ang_ext - DEG180;
      ang_flip = 1'b1;
    end else if (ang_ext < -DEG90) begin
      ang_red  = ang_ext + DEG180;
      ang_flip = 1'b1;
    end

    xs        = x_q >>> it_q;
    ys        = y_q >>> it_q;
    atan_s    = $signed({4'b0000, atan_q30(5'(it_q))});
    cord_last = (it_q == IW'(CORDIC_ITERATIONS - 1));
    if (!z_q[33]) begin
      x_n = x_q - ys;
      y_n = y_q + xs;
      z_n = z_q - atan_s;
    end else begin
      x_n = x_q + ys;
      y_n = y_q - xs;
      z_n = z_q + atan_s;
    end

    ax = sat32(dx_q);
    ay = sat32(dy_q - $signed({19'b0, gr_q}));

    ex   = {px_q[31], px_q} - {tx_q[31], tx_q};
    ey   = {py_q[31], py_q} - {ty_q[31], ty_q};
    ex_m = ex[32] ? 33'(-ex) : 33'(ex);
    ey_m = ey[32] ? 33'(-ey) : 33'(ey);
    far  = ex_m[32] || ex_m[31] || ey_m[32] || ey_m[31];

    el_sum = {1'b0, el_q} + 33'((34'(dt_q) + 34'h0008000) >> 16);

    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_ANG: begin
        mul_a = {8'b0, 24'(mag34(34'(ang_q)))};
        mul_b = DEG_TO_RAD;
      end
      S_VX: begin
        mul_a = 32'(mag34(x_q));
        mul_b = {8'b0, spd_q};
      end
      S_VY: begin
        mul_a = 32'(mag34(y_q));
        mul_b = {8'b0, spd_q};
      end
      S_SQX: begin
        mul_a = mag32(rx_q);
        mul_b = mag32(rx_q);
      end
      S_SQY: begin
        mul_a = mag32(ry_q);
        mul_b = mag32(ry_q);
      end
      S_K: begin
        mul_a = df_q;
        mul_b = sq_root;
      end
      S_DX: begin
        mul_a = mag32(rx_q);
        mul_b = prod_q[63:32];
      end
      S_DY: begin
        mul_a = mag32(ry_q);
        mul_b = k_q;
      end
      S_AX: begin
        mul_a = mag32(ax);
        mul_b = dt_q;
      end
      S_AY: begin
        mul_a = mag32(ay);
        mul_b = dt_q;
      end
      S_PX: begin
        mul_a = mag32(vx_q);
        mul_b = dt_q;
      end
      S_PY: begin
        mul_a = mag32(vy_q);
        mul_b = dt_q;
      end
      S_CHK: begin
        mul_a = ex_m[31:0];
        mul_b = ex_m[31:0];
      end
      S_EY: begin
        mul_a = ey_m[31:0];
        mul_b = ey_m[31:0];
      end
      S_R2: begin
        mul_a = {1'b0, tr_q};
        mul_b = {1'b0, tr_q};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      wx_q     <= RST_WIND_X;
      wy_q     <= RST_WIND_Y;
      tx_q     <= RST_TARGET_X;
      ty_q     <= RST_TARGET_Y;
      tr_q     <= RST_RADIUS;
      df_q     <= RST_DRAG;
      gr_q     <= RST_GRAVITY;
      dt_q     <= RST_DT;
      px_q     <= '0;
      py_q     <= START_Y;
      vx_q     <= '0;
      vy_q     <= '0;
      el_q     <= '0;
      flying_q <= 1'b0;
      hit_q    <= 1'b0;
      paused_q <= 1'b0;
      step_q   <= 1'b0;
      cnt_q    <= '0;
      ov_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          REG_WIND_X:   wx_q <= cfg_data_i;
          REG_WIND_Y:   wy_q <= cfg_data_i;
          REG_TARGET_X: tx_q <= cfg_data_i;
          REG_TARGET_Y: ty_q <= cfg_data_i;
          REG_RADIUS:   tr_q <= cfg_data_i[30:0];
          REG_DRAG:     df_q <= cfg_data_i;
          REG_GRAVITY:  gr_q <= cfg_data_i[30:0];
          REG_DT:       dt_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (out_load) begin
        ov_q <= 1'b1;
      end else if (res_o.ready) begin
        ov_q <= 1'b0;
      end

      case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            case (op_e'(in_i.op))
              OP_TICK: begin
                if (tick_runs) begin
                  step_q  <= 1'b0;
                  cnt_q   <= '0;
                  state_q <= S_REL;
                end
              end
              OP_LAUNCH, OP_RESET: begin
                px_q     <= '0;
                py_q     <= START_Y;
                vx_q     <= '0;
                vy_q     <= '0;
                el_q     <= '0;
                flying_q <= 1'b0;
                hit_q    <= 1'b0;
                paused_q <= 1'b0;
                step_q   <= 1'b0;
                if (in_i.op == OP_LAUNCH) begin
                  state_q <= S_ANG;
                end
              end
              OP_PAUSE: paused_q <= in_i.pause_value;
              OP_STEP:  step_q   <= 1'b1;
              default: ;
            endcase
          end
        end
        S_ANG:   state_q <= S_CINIT;
        S_CINIT: state_q <= S_CORD;
        S_CORD: begin
          if (cord_last) begin
            state_q <= S_VX;
          end
        end
        S_VX: state_q <= S_VY;
        S_VY: begin
          vx_q    <= sat32(smag(x_q[33] ^ flip_q, 48'(prod_q >> 30)));
          state_q <= S_VYW;
        end
        S_VYW: begin
          vy_q     <= sat32(smag(y_q[33] ^ flip_q, 48'(prod_q >> 30)));
          flying_q <= 1'b1;
          state_q  <= S_IDLE;
        end
        S_REL: state_q <= S_SQX;
        S_SQX: state_q <= S_SQY;
        S_SQY: state_q <= S_SQS;
        S_SQS: state_q <= S_SQW;
        S_SQW: begin
          if (sq_done) begin
            state_q <= (sq_root >= DRAG_MIN) ? S_K : S_AX;
          end
        end
        S_K:   state_q <= S_DX;
        S_DX:  state_q <= S_DY;
        S_DY:  state_q <= S_DYW;
        S_DYW: state_q <= S_AX;
        S_AX:  state_q <= S_AY;
        S_AY: begin
          vx_q    <= sat32(ext50(vx_q) + smag(ax[31], 48'(prod_q >> 32)));
          state_q <= S_PX;
        end
        S_PX: begin
          vy_q    <= sat32(ext50(vy_q) + smag(ay[31], 48'(prod_q >> 32)));
          state_q <= S_PY;
        end
        S_PY: begin
          px_q    <= sat32(ext50(px_q) + smag(vx_q[31], 48'(prod_q >> 32)));
          state_q <= S_PYW;
        end
        S_PYW: begin
          py_q    <= sat32(ext50(py_q) + smag(vy_q[31], 48'(prod_q >> 32)));
          el_q    <= el_sum[32] ? 32'hffffffff : el_sum[31:0];
          state_q <= S_CHK;
        end
        S_CHK: begin
          if (py_q[31] || (py_q == 32'sd0)) begin
            flying_q <= 1'b0;
            state_q  <= S_OUT;
          end else if (far) begin
            state_q <= S_OUT;
          end else begin
            state_q <= S_EY;
          end
        end
        S_EY: state_q <= S_R2;
        S_R2: state_q <= S_HIT;
        S_HIT: begin
          if (acc_q <= prod_q) begin
            flying_q <= 1'b0;
            hit_q    <= 1'b1;
          end
          state_q <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            if (sub_last) begin
              state_q <= S_IDLE;
            end else begin
              cnt_q   <= cnt_q + SW'(1);
              state_q <= S_REL;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        spd_q  <= in_i.launch_speed;
        ang_q  <= ang_red;
        flip_q <= ang_flip;
      end
      S_CINIT: begin
        z_q  <= 34'(smag(ang_q[24], 48'(prod_q >> 18)));
        x_q  <= CORDIC_GAIN;
        y_q  <= '0;
        it_q <= '0;
      end
      S_CORD: begin
        x_q  <= x_n;
        y_q  <= y_n;
        z_q  <= z_n;
        it_q <= it_q + IW'(1);
      end
      S_REL: begin
        rx_q <= sat32(ext50(vx_q) - ext50(wx_q));
        ry_q <= sat32(ext50(vy_q) - ext50(wy_q));
      end
      S_SQY: acc_q <= prod_q;
      S_SQW: begin
        dx_q <= '0;
        dy_q <= '0;
      end
      S_DX: k_q <= prod_q[63:32];
      S_DY: dx_q <= smag(!rx_q[31], 48'(prod_q >> 16));
      S_DYW: dy_q <= smag(!ry_q[31], 48'(prod_q >> 16));
      S_EY: acc_q <= prod_q;
      S_R2: acc_q <= acc_q + prod_q;
      default: ;
    endcase

    if (out_load) begin
      opx_q   <= px_q;
      opy_q   <= py_q;
      ovx_q   <= vx_q;
      ovy_q   <= vy_q;
      oel_q   <= el_q;
      ofly_q  <= flying_q;
      ohit_q  <= hit_q;
      olast_q <= sub_last;
    end
  end

  assign res_o.valid      = ov_q;
  assign res_o.pos_x      = opx_q;
  assign res_o.pos_y      = opy_q;
  assign res_o.vel_x      = ovx_q;
  assign res_o.vel_y      = ovy_q;
  assign res_o.elapsed    = oel_q;
  assign res_o.in_flight  = ofly_q;
  assign res_o.target_hit = ohit_q;
  assign res_o.last       = olast_q;

  `PDI_ASSERT_IMP(a_hit_ends_flight, hit_q, !flying_q)
  `PDI_ASSERT_NXT(a_tick_busy, in_fire && (in_i.op == OP_TICK) && tick_runs, !in_i.ready)
  `PDI_ASSERT_NXT(a_last_to_idle, out_load && sub_last, state_q == S_IDLE)

endmodule

`default_nettype wire
